// File: src/sccb_pkg.sv
// Shared types, codes and sequence tables for the SCCB register access master.
// No dependencies; every other file in src except sccb_checker imports this package.
`timescale 1ns / 1ps
`default_nettype none

package sccb_pkg;

  // Input word kinds.
  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_DEVICE_ADDRESS = 1'b0;
  localparam logic CFG_PHASE_TICKS    = 1'b1;

  // Bus segment codes.
  localparam logic [3:0] SEG_START = 4'd0;
  localparam logic [3:0] SEG_ADDRW = 4'd1;
  localparam logic [3:0] SEG_ADDRR = 4'd2;
  localparam logic [3:0] SEG_REG   = 4'd3;
  localparam logic [3:0] SEG_DATA  = 4'd4;
  localparam logic [3:0] SEG_ACK   = 4'd5;
  localparam logic [3:0] SEG_STOP  = 4'd6;
  localparam logic [3:0] SEG_READ  = 4'd7;
  localparam logic [3:0] SEG_NACK  = 4'd8;

  // Index of the final segment of each transaction kind.
  localparam logic [3:0] WR_LAST_SEG = 4'd7;
  localparam logic [3:0] RD_LAST_SEG = 4'd11;

  localparam int TDATA_IN_W  = 24;
  localparam int TDATA_OUT_W = 16;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] reg_addr;
    logic [7:0] write_data;
    logic       sda_in;
  } item_t;

  typedef struct packed {
    logic [2:0] ack_bits;
    logic [7:0] read_data;
    logic       done_res;
    logic       busy_res;
    logic       sda_out;
    logic       scl;
  } result_t;

  typedef struct packed {
    logic [6:0]  device_address;
    logic [15:0] phase_ticks;
  } cfg_t;

  // Segment found at a given position of a write or read transaction.
  function automatic logic [3:0] seq_seg(input logic is_read, input logic [3:0] idx);
    logic [3:0] s;
    s = SEG_STOP;
    if (is_read) begin
      unique case (idx)
        4'd0:    s = SEG_START;
        4'd1:    s = SEG_ADDRW;
        4'd2:    s = SEG_ACK;
        4'd3:    s = SEG_REG;
        4'd4:    s = SEG_ACK;
        4'd5:    s = SEG_STOP;
        4'd6:    s = SEG_START;
        4'd7:    s = SEG_ADDRR;
        4'd8:    s = SEG_ACK;
        4'd9:    s = SEG_READ;
        4'd10:   s = SEG_NACK;
        default: s = SEG_STOP;
      endcase
    end else begin
      unique case (idx)
        4'd0:    s = SEG_START;
        4'd1:    s = SEG_ADDRW;
        4'd2:    s = SEG_ACK;
        4'd3:    s = SEG_REG;
        4'd4:    s = SEG_ACK;
        4'd5:    s = SEG_DATA;
        4'd6:    s = SEG_ACK;
        default: s = SEG_STOP;
      endcase
    end
    return s;
  endfunction

  // Which acknowledge bit an ack slot at a given position reports.
  function automatic logic [1:0] ack_slot(input logic [3:0] idx);
    logic [1:0] a;
    a = 2'd2;
    unique case (idx)
      4'd2:    a = 2'd0;
      4'd4:    a = 2'd1;
      default: a = 2'd2;
    endcase
    return a;
  endfunction

  // Offset of the final phase within a segment.
  function automatic logic [4:0] seg_last(input logic [3:0] s);
    logic [4:0] n;
    n = 5'd23;
    unique case (s)
      SEG_START: n = 5'd2;
      SEG_ACK:   n = 5'd1;
      SEG_STOP:  n = 5'd1;
      SEG_READ:  n = 5'd16;
      SEG_NACK:  n = 5'd3;
      default:   n = 5'd23;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

// File: src/sccb_register_access_master_core.sv
// Top level of the SCCB register access master: configuration registers, stream packing,
// and the input register and phase engine. Depends on sccb_pkg, sccb_in_reg, sccb_phase_engine.
`timescale 1ns / 1ps
`default_nettype none

// The block is an SCCB (I2C style) master that performs one register write or one
// register read per command, stepping the bus one phase at a time. Every input word
// is a tick or a command; each accepted word yields exactly one output word that
// shows the SCL and SDA levels being driven, whether a transaction is running,
// whether this word finished one, the byte of the last read and the acknowledge
// bits (bit 0 for the first byte, set when the target pulled SDA low). A write takes
// 83 phases and a read 109 phases; one phase completes every phase_ticks tick words.
// Commands that arrive while a transaction runs are dropped. The block accepts one
// word per clock cycle while the output is not stalled; a word goes from the input
// register through the single combinational phase step into the output register,
// and the rate is held by the next-state loop of the phase engine. Configuration
// writes take effect at once and are always ready.
module sccb_register_access_master_core (
  input  wire        clk,
  input  wire        rst,
  // Input stream.
  input  wire        s_tvalid,
  output logic       s_tready,
  input  wire [1:0]  s_tuser,  // kind[1:0]
  input  wire [sccb_pkg::TDATA_IN_W-1:0] s_tdata,
                               // reg_addr[7:0], write_data[15:8], sda_in[16], zeros[23:17]
  // Output stream.
  output logic       m_tvalid,
  input  wire        m_tready,
  output logic [sccb_pkg::TDATA_OUT_W-1:0] m_tdata,
                               // scl[0], sda_out[1], busy_res[2], done_res[3],
                               // read_data[11:4], ack_bits[14:12], zero[15]
  // Configuration write channel.
  input  wire        cfg_valid,
  output logic       cfg_ready,
  input  wire        cfg_index,
  input  wire [15:0] cfg_data
);
  import sccb_pkg::*;

  cfg_t    cfg;
  item_t   item;
  result_t result;
  logic    item_valid;
  logic    take;

  // Register writes are taken in any cycle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.device_address <= 7'd33;
      cfg.phase_ticks    <= 16'd1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_DEVICE_ADDRESS: cfg.device_address <= cfg_data[6:0];
        CFG_PHASE_TICKS:    cfg.phase_ticks    <= cfg_data;
        default:            cfg.phase_ticks    <= cfg.phase_ticks;
      endcase
    end
  end

  sccb_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tuser    (s_tuser),
    .s_tdata    (s_tdata),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  sccb_phase_engine u_engine (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .cfg        (cfg),
    .take       (take),
    .m_tready   (m_tready),
    .m_tvalid   (m_tvalid),
    .result     (result)
  );

  // The result struct is declared in the same bit order as the output word.
  assign m_tdata = {1'b0, result};

endmodule

`default_nettype wire

// File: src/sccb_in_reg.sv
// Input register stage: captures one stream word and holds it for the phase engine.
// Depends on sccb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sccb_in_reg (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 s_tvalid,
  output logic                s_tready,
  input  wire [1:0]           s_tuser,
  input  wire [sccb_pkg::TDATA_IN_W-1:0] s_tdata,
  input  wire                 take,
  output logic                item_valid,
  output sccb_pkg::item_t     item
);
  import sccb_pkg::*;

  // The slot frees up in the same cycle the engine consumes it.
  assign s_tready = !item_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      item_valid <= 1'b1;
    end else if (take) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item.kind       <= s_tuser;
      item.reg_addr   <= s_tdata[7:0];
      item.write_data <= s_tdata[15:8];
      item.sda_in     <= s_tdata[16];
    end
  end

endmodule

`default_nettype wire

// File: src/sccb_phase_engine.sv
// Bus phase sequencer: transaction state, at most one phase step per word, and the result register.
// Depends on sccb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sccb_phase_engine (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 item_valid,
  input  sccb_pkg::item_t     item,
  input  sccb_pkg::cfg_t      cfg,
  output logic                take,
  input  wire                 m_tready,
  output logic                m_tvalid,
  output sccb_pkg::result_t   result
);
  import sccb_pkg::*;

  logic        busy, busy_next;
  logic        is_read, is_read_next;
  logic [3:0]  seg, seg_next;
  logic [4:0]  off, off_next;
  logic [2:0]  bitn, bitn_next;
  logic [1:0]  sub, sub_next;
  logic [15:0] tick_count, tick_count_next;
  logic [7:0]  latched_register, latched_register_next;
  logic [7:0]  latched_data, latched_data_next;
  logic [7:0]  shift_byte, shift_byte_next;
  logic [2:0]  ack_flags, ack_flags_next;
  logic        scl, scl_next;
  logic        sda, sda_next;
  logic        done;

  logic        fire;
  logic        is_cmd;
  logic [16:0] tick_inc;
  logic [16:0] tick_lim;
  logic [3:0]  seg_code;
  logic        seg_end;
  logic [7:0]  tx_byte;
  logic [3:0]  last_seg;

  assign take = item_valid && (!m_tvalid || m_tready);

  always_comb begin
    busy_next             = busy;
    is_read_next          = is_read;
    seg_next              = seg;
    off_next              = off;
    bitn_next             = bitn;
    sub_next              = sub;
    tick_count_next       = tick_count;
    latched_register_next = latched_register;
    latched_data_next     = latched_data;
    shift_byte_next       = shift_byte;
    ack_flags_next        = ack_flags;
    scl_next              = scl;
    sda_next              = sda;
    done                  = 1'b0;
    fire                  = 1'b0;

    is_cmd   = (item.kind == KIND_WRITE) || (item.kind == KIND_READ);
    tick_inc = {1'b0, tick_count} + 17'd1;
    tick_lim = (cfg.phase_ticks == 16'd0) ? 17'd1 : {1'b0, cfg.phase_ticks};
    seg_code = seq_seg(is_read, seg);
    seg_end  = (off == seg_last(seg_code));
    last_seg = is_read ? RD_LAST_SEG : WR_LAST_SEG;

    case (seg_code)
      SEG_ADDRW: tx_byte = {cfg.device_address, 1'b0};
      SEG_ADDRR: tx_byte = {cfg.device_address, 1'b1};
      SEG_REG:   tx_byte = latched_register;
      default:   tx_byte = latched_data;
    endcase

    if (is_cmd) begin
      // A command while a transaction runs is dropped without counting a tick.
      if (!busy) begin
        busy_next             = 1'b1;
        is_read_next          = (item.kind == KIND_READ);
        latched_register_next = item.reg_addr;
        if (item.kind == KIND_WRITE) begin
          latched_data_next = item.write_data;
        end
        ack_flags_next  = 3'd0;
        tick_count_next = 16'd0;
        seg_next        = 4'd0;
        off_next        = 5'd0;
        bitn_next       = 3'd0;
        sub_next        = 2'd0;
      end
    end else if (busy) begin
      if (tick_inc >= tick_lim) begin
        tick_count_next = 16'd0;
        fire            = 1'b1;
      end else begin
        tick_count_next = tick_inc[15:0];
      end
    end

    if (fire) begin
      unique case (seg_code)
        SEG_START: begin
          scl_next = (off != 5'd2);
          sda_next = (off == 5'd0);
        end
        SEG_ACK: begin
          if (off == 5'd0) begin
            scl_next = 1'b1;
            sda_next = 1'b1;
          end else begin
            if (!item.sda_in) begin
              ack_flags_next[ack_slot(seg)] = 1'b1;
            end
            scl_next = 1'b0;
            sda_next = 1'b1;
          end
        end
        SEG_STOP: begin
          scl_next = 1'b1;
          sda_next = (off != 5'd0);
        end
        SEG_READ: begin
          sda_next = 1'b1;
          if (off == 5'd0) begin
            shift_byte_next = 8'd0;
            scl_next        = 1'b0;
          end else if (off[0]) begin
            // Odd offsets raise SCL and sample SDA, MSB first.
            scl_next = 1'b1;
            shift_byte_next[3'd7 - off[3:1]] = shift_byte[3'd7 - off[3:1]] | item.sda_in;
          end else begin
            scl_next = 1'b0;
          end
        end
        SEG_NACK: begin
          scl_next = (off == 5'd1);
          sda_next = (off != 5'd3);
        end
        default: begin
          // Byte segments: three phases per bit, SCL high in the middle one.
          scl_next = (sub == 2'd1);
          sda_next = tx_byte[3'd7 - bitn];
        end
      endcase

      if (seg_end) begin
        off_next  = 5'd0;
        bitn_next = 3'd0;
        sub_next  = 2'd0;
        if (seg == last_seg) begin
          busy_next = 1'b0;
          done      = 1'b1;
          seg_next  = 4'd0;
        end else begin
          seg_next = seg + 4'd1;
        end
      end else begin
        off_next = off + 5'd1;
        if (sub == 2'd2) begin
          sub_next  = 2'd0;
          bitn_next = bitn + 3'd1;
        end else begin
          sub_next = sub + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy             <= 1'b0;
      is_read          <= 1'b0;
      seg              <= 4'd0;
      off              <= 5'd0;
      bitn             <= 3'd0;
      sub              <= 2'd0;
      tick_count       <= 16'd0;
      latched_register <= 8'd0;
      latched_data     <= 8'd0;
      shift_byte       <= 8'd0;
      ack_flags        <= 3'd0;
      scl              <= 1'b1;
      sda              <= 1'b1;
      m_tvalid         <= 1'b0;
    end else begin
      if (take) begin
        busy             <= busy_next;
        is_read          <= is_read_next;
        seg              <= seg_next;
        off              <= off_next;
        bitn             <= bitn_next;
        sub              <= sub_next;
        tick_count       <= tick_count_next;
        latched_register <= latched_register_next;
        latched_data     <= latched_data_next;
        shift_byte       <= shift_byte_next;
        ack_flags        <= ack_flags_next;
        scl              <= scl_next;
        sda              <= sda_next;
        m_tvalid         <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result.scl       <= scl_next;
      result.sda_out   <= sda_next;
      result.busy_res  <= busy_next;
      result.done_res  <= done;
      result.read_data <= shift_byte_next;
      result.ack_bits  <= ack_flags_next;
    end
  end

endmodule

`default_nettype wire

// File: src/sccb_checker.sv
// Port-level checks for the SCCB register access master, bound to the top level.
// Depends on sccb_register_access_master_core for the bind target.
`timescale 1ns / 1ps
`default_nettype none

module sccb_checker (
  input wire        clk,
  input wire        rst,
  input wire        m_tvalid,
  input wire        m_tready,
  input wire [15:0] m_tdata
);

  // A stalled output word stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output word changed while stalled");

  // No output word is offered right after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  // The word that finishes a transaction reports it as no longer running.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[3] |-> !m_tdata[2])
    else $error("done reported while busy");

  // With no transaction running both bus lines rest high.
  a_idle_lines: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[2] |-> m_tdata[0] && m_tdata[1])
    else $error("bus lines not released while idle");

endmodule

bind sccb_register_access_master_core sccb_checker u_sccb_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire

// File: sim/sccb_register_access_master_core_test.sv
// Self-checking bench for the SCCB register access master: stream words in, bus levels out.
// Depends on sccb_pkg and the RTL top sccb_register_access_master_core only.
`timescale 1ns / 1ps

module sccb_register_access_master_core_test;
  import sccb_pkg::*;

  // The spare kind code behaves as a tick.
  localparam logic [1:0] KIND_SPARE = 2'd3;
  localparam int unsigned WR_PHASES = 83;
  localparam int unsigned RD_PHASES = 109;
  localparam int unsigned LONG_HOLD = 300;

  localparam logic [3:0] WR_PLAN [8] = '{SEG_START, SEG_ADDRW, SEG_ACK, SEG_REG,
                                         SEG_ACK, SEG_DATA, SEG_ACK, SEG_STOP};
  localparam logic [3:0] RD_PLAN [12] = '{SEG_START, SEG_ADDRW, SEG_ACK, SEG_REG,
                                          SEG_ACK, SEG_STOP, SEG_START, SEG_ADDRR,
                                          SEG_ACK, SEG_READ, SEG_NACK, SEG_STOP};

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [1:0]             s_tuser = '0;
  logic [TDATA_IN_W-1:0]  s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [TDATA_OUT_W-1:0] m_tdata;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic                   cfg_index = 1'b0;
  logic [15:0]            cfg_data = '0;

  sccb_register_access_master_core u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Words waiting to be sent and bus words still owed by the block.
  item_t   cmd_queue [$];
  result_t want_words [$];
  int      err_count = 0;
  int      gap_pct = 20;
  logic    hold_req = 1'b0;
  int      src_gap = 0;
  int      sink_gap = 0;
  int      hold_left = 0;

  // Predicted master state.
  logic [6:0]  cur_addr = 7'd33;
  logic [15:0] cur_ticks = 16'd1;
  int unsigned tick_cnt = 0;
  int unsigned phase_no = 0;   // 0 idle, else one more than the phases done
  logic        rd_mode = 1'b0;
  logic [7:0]  reg_latch = '0;
  logic [7:0]  data_latch = '0;
  logic [7:0]  rd_shift = '0;
  logic [2:0]  ack_seen = '0;
  logic        scl_lvl = 1'b1;
  logic        sda_lvl = 1'b1;

  function automatic int unsigned seg_span(logic [3:0] s);
    case (s)
      SEG_START: return 3;
      SEG_ACK:   return 2;
      SEG_STOP:  return 2;
      SEG_READ:  return 17;
      SEG_NACK:  return 4;
      default:   return 24;
    endcase
  endfunction

  // Drives the lines for phase p of the running transaction; true on its final phase.
  function automatic logic bus_phase(int unsigned p, logic sda_bit);
    int unsigned nseg, base, span, total, o, k, acks, i;
    logic [3:0]  s;
    logic [7:0]  octet;
    logic        hit;
    nseg = rd_mode ? 12 : 8;
    base = 0;
    total = 0;
    acks = 0;
    hit = 1'b0;
    for (i = 0; i < nseg; i++) begin
      s = rd_mode ? RD_PLAN[i] : WR_PLAN[i];
      span = seg_span(s);
      if (!hit && p < base + span) begin
        hit = 1'b1;
        o = p - base;
        case (s)
          SEG_START: begin
            scl_lvl = (o != 2);
            sda_lvl = (o == 0);
          end
          SEG_ACK: begin
            if (o != 0 && !sda_bit) ack_seen[acks] = 1'b1;
            scl_lvl = (o == 0);
            sda_lvl = 1'b1;
          end
          SEG_STOP: begin
            scl_lvl = 1'b1;
            sda_lvl = (o != 0);
          end
          SEG_READ: begin
            sda_lvl = 1'b1;
            if (o == 0) begin
              rd_shift = '0;
              scl_lvl = 1'b0;
            end else begin
              k = o - 1;
              scl_lvl = (k % 2 == 0);
              if (k % 2 == 0) rd_shift[7 - k / 2] = sda_bit;
            end
          end
          SEG_NACK: begin
            scl_lvl = (o == 1);
            sda_lvl = (o != 3);
          end
          default: begin
            if (s == SEG_ADDRW) octet = {cur_addr, 1'b0};
            else if (s == SEG_ADDRR) octet = {cur_addr, 1'b1};
            else if (s == SEG_REG) octet = reg_latch;
            else octet = data_latch;
            scl_lvl = (o % 3 == 1);
            sda_lvl = octet[7 - o / 3];
          end
        endcase
      end
      // Only ack slots ahead of the current phase pick the bit it reports.
      if (!hit && s == SEG_ACK) acks++;
      base += span;
      total += span;
    end
    return (p + 1 >= total);
  endfunction

  function automatic result_t bus_step(item_t it);
    result_t     r;
    logic        fin;
    int unsigned lim;
    fin = 1'b0;
    if (it.kind == KIND_WRITE || it.kind == KIND_READ) begin
      // A command while a transaction runs is dropped without counting a tick.
      if (phase_no == 0) begin
        rd_mode = (it.kind == KIND_READ);
        reg_latch = it.reg_addr;
        if (it.kind == KIND_WRITE) data_latch = it.write_data;
        ack_seen = '0;
        tick_cnt = 0;
        phase_no = 1;
      end
    end else if (phase_no != 0) begin
      lim = (cur_ticks == 0) ? 1 : cur_ticks;
      tick_cnt++;
      if (tick_cnt >= lim) begin
        tick_cnt = 0;
        if (bus_phase(phase_no - 1, it.sda_in)) begin
          phase_no = 0;
          fin = 1'b1;
        end else begin
          phase_no++;
        end
      end
    end
    r.scl = scl_lvl;
    r.sda_out = sda_lvl;
    r.busy_res = (phase_no != 0);
    r.done_res = fin;
    r.read_data = rd_shift;
    r.ack_bits = ack_seen;
    return r;
  endfunction

  task automatic field_check(string what, int unsigned want, int unsigned got);
    if (want != got) begin
      err_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
    end
  endtask

  task automatic check_word(logic [TDATA_OUT_W-1:0] word);
    result_t got, want;
    got = result_t'(word[14:0]);
    if (want_words.size() == 0) begin
      err_count++;
      $display("%0t: word %h arrived with nothing expected", $time, word);
    end else begin
      want = want_words.pop_front();
      field_check("scl", want.scl, got.scl);
      field_check("sda_out", want.sda_out, got.sda_out);
      field_check("busy_res", want.busy_res, got.busy_res);
      field_check("done_res", want.done_res, got.done_res);
      field_check("read_data", want.read_data, got.read_data);
      field_check("ack_bits", want.ack_bits, got.ack_bits);
      field_check("pad bit", 0, word[15]);
    end
  endtask

  // Sender: presents the head of the command queue, with random gaps.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        want_words.push_back(bus_step(cmd_queue[0]));
        void'(cmd_queue.pop_front());
      end
      if (s_tvalid && !s_tready) begin
        // Word still on offer: hold it.
      end else if (src_gap > 0) begin
        src_gap--;
        s_tvalid <= 1'b0;
      end else if (cmd_queue.size() == 0) begin
        s_tvalid <= 1'b0;
      end else if ($urandom_range(0, 99) < gap_pct) begin
        src_gap = $urandom_range(0, 10);
        s_tvalid <= 1'b0;
      end else begin
        s_tvalid <= 1'b1;
        s_tuser  <= cmd_queue[0].kind;
        s_tdata  <= {7'd0, cmd_queue[0].sda_in, cmd_queue[0].write_data,
                     cmd_queue[0].reg_addr};
      end
    end
  end

  // Receiver: checks every word taken and stalls at random or on request.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) check_word(m_tdata);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap--;
        m_tready <= 1'b0;
      end else if ($urandom_range(0, 99) < gap_pct) begin
        sink_gap = $urandom_range(0, 10);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic queue_word(logic [1:0] kind, logic [7:0] ra, logic [7:0] wd, logic sda);
    item_t it;
    it.kind = kind;
    it.reg_addr = ra;
    it.write_data = wd;
    it.sda_in = sda;
    cmd_queue.push_back(it);
  endtask

  // Ticks with noise in the unused fields; sda_pick below zero means a random level.
  // With noise set, stray commands land in between and must be dropped.
  task automatic queue_ticks(int unsigned n, int sda_pick, logic noise);
    int unsigned i;
    logic        sda;
    for (i = 0; i < n; i++) begin
      sda = (sda_pick < 0) ? 1'($urandom) : 1'(sda_pick);
      if (noise && i + 1 < n && $urandom_range(0, 19) == 0)
        queue_word($urandom_range(0, 1) ? KIND_WRITE : KIND_READ, 8'($urandom),
                   8'($urandom), sda);
      queue_word($urandom_range(0, 7) == 0 ? KIND_SPARE : KIND_TICK, 8'($urandom),
                 8'($urandom), sda);
    end
  endtask

  task automatic wait_drained();
    while (cmd_queue.size() != 0 || s_tvalid || want_words.size() != 0) @(posedge clk);
  endtask

  // Lets any running transaction finish so the registers can be touched.
  task automatic settle();
    wait_drained();
    while (phase_no != 0) begin
      queue_ticks(40, -1, 1'b0);
      wait_drained();
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cfg(logic idx, logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_DEVICE_ADDRESS) cur_addr = val[6:0];
    else cur_ticks = val;
  endtask

  // Mostly complete transactions with random content; some are cut short so that
  // the next command arrives while busy, and some idle ticks come in between.
  task automatic random_traffic(int unsigned budget, int unsigned per_phase);
    int unsigned sent, n;
    logic [1:0]  k;
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(0, 4) == 0) queue_ticks($urandom_range(1, 4), -1, 1'b0);
      k = $urandom_range(0, 1) ? KIND_WRITE : KIND_READ;
      n = (k == KIND_READ ? RD_PHASES : WR_PHASES) * per_phase;
      if ($urandom_range(0, 5) == 0) n = $urandom_range(1, n);
      queue_word(k, 8'($urandom), 8'($urandom), 1'($urandom));
      queue_ticks(n, -1, 1'b1);
      sent += n + 1;
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: idle ticks are ignored, then a write and a read at the field extremes.
    queue_word(KIND_TICK, 8'hFF, 8'hFF, 1'b1);
    queue_word(KIND_SPARE, 8'h00, 8'h00, 1'b0);
    queue_word(KIND_WRITE, 8'hFF, 8'h00, 1'b0);
    queue_ticks(WR_PHASES, 0, 1'b0);
    queue_word(KIND_READ, 8'h00, 8'hFF, 1'b1);
    queue_ticks(5, 1, 1'b0);
    queue_word(KIND_WRITE, 8'h5A, 8'hC3, 1'b0);  // dropped: read in progress
    queue_ticks(RD_PHASES - 5, 1, 1'b0);
    settle();

    // Lowest address and a zero tick count, which behaves as one.
    write_cfg(CFG_DEVICE_ADDRESS, 16'h0000);
    write_cfg(CFG_PHASE_TICKS, 16'h0000);
    random_traffic(80, 1);
    settle();

    // Highest address, with the upper data bits set; a long receiver stall
    // while the sender keeps offering words.
    gap_pct = 25;
    write_cfg(CFG_DEVICE_ADDRESS, 16'hFFFF);
    write_cfg(CFG_PHASE_TICKS, 16'd2);
    random_traffic(100, 2);
    hold_req = 1'b1;
    settle();

    // Last part runs with no idling on either side.
    gap_pct = 0;
    write_cfg(CFG_DEVICE_ADDRESS, 16'($urandom_range(0, 127)));
    write_cfg(CFG_PHASE_TICKS, 16'd1);
    random_traffic(80, 1);
    settle();
    repeat (10) @(posedge clk);

    if (err_count == 0) begin
      $display("PASS sccb_register_access_master_core");
    end else begin
      $display("FAIL sccb_register_access_master_core");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("FAIL sccb_register_access_master_core");
    $finish;
  end

endmodule
